// ===== rtl/alef_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alef_pkg
// Shared types, constants and helpers of the anchored line entry filter.
// ----------------------------------------------------------------------------
package alef_pkg;

   localparam int PATTERN_MAX_DEF  = 32;
   localparam int LINE_LEN_MAX_DEF = 1023;
   localparam int PATTERN_BYTES    = 32;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;
   localparam logic [7:0] SPACE_BYTE   = 8'd32;
   localparam logic [7:0] TAB_BYTE     = 8'd9;
   localparam logic [7:0] CR_BYTE      = 8'd13;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MATCH_MODE     = 3'd0,
      CSR_PATTERN_LENGTH = 3'd1,
      CSR_PATTERN_0_7    = 3'd2,
      CSR_PATTERN_8_15   = 3'd3,
      CSR_PATTERN_16_23  = 3'd4,
      CSR_PATTERN_24_31  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_SUBSTRING = 2'd0,
      MODE_PREFIX    = 2'd1,
      MODE_SUFFIX    = 2'd2,
      MODE_EXACT     = 2'd3
   } match_mode_type;

   typedef logic [PATTERN_BYTES-1:0][7:0] pattern_type;

   function automatic logic is_blank(input logic [7:0] b);
      return (b == SPACE_BYTE) || ((b >= TAB_BYTE) && (b <= CR_BYTE));
   endfunction

endpackage
`default_nettype wire

// ===== rtl/alef_tail_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alef_tail_match
// Checks that the newest match_len window bytes equal the pattern, read
// oldest to newest. One parallel byte compare per window tap.
// ----------------------------------------------------------------------------
module alef_tail_match #(
   parameter int PATTERN_MAX = alef_pkg::PATTERN_MAX_DEF,
   parameter int PW          = 6
) (
   input  wire logic [PATTERN_MAX-1:0][7:0] window_bytes,
   input  wire alef_pkg::pattern_type       pattern,
   input  wire logic [PW-1:0]               match_len,
   output logic                             tail_hit
);
   import alef_pkg::*;

   logic [PATTERN_MAX-1:0][6:0] pat_idx;
   logic [PATTERN_MAX-1:0][7:0] pat_sel;
   logic [PATTERN_MAX-1:0]      tap_ok;

   // tap k (newest first) lines up with pattern byte match_len-1-k
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         pat_idx[k] = 7'(match_len) - 7'(k) - 7'd1;
         if (32'(pat_idx[k]) < PATTERN_BYTES) begin
            pat_sel[k] = pattern[pat_idx[k][4:0]];
         end else begin
            pat_sel[k] = 8'h00;
         end
         tap_ok[k] = (32'(k) >= 32'(match_len)) || (window_bytes[k] == pat_sel[k]);
      end
   end

   assign tail_hit = &tap_ok;

endmodule
`default_nettype wire

// ===== rtl/anchored_line_entry_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anchored_line_entry_filter
// Splits a text byte stream into lines and flags the lines of entries whose
// header line matches the pattern (substring, prefix, suffix or exact).
// ----------------------------------------------------------------------------
//  channel  dir  handshake          beat contents
//  req      in   valid / stall      text_byte
//  rsp      out  valid / stall      line_selected, starts_entry, line_length
//  csr      in   valid / ready      index, data (64 bit)
//
//  One byte per cycle while no newline is held back: a beat waits in the input
//  register, then the window compare and line state update complete at once.
//  A newline result is written to the output register as its beat advances.
//  Reset (synchronous) clears configuration, line state, byte window and valid flags.
//  A newline stalls in the input register only while a result waits stalled.
// ----------------------------------------------------------------------------
module anchored_line_entry_filter #(
   parameter int PATTERN_MAX  = alef_pkg::PATTERN_MAX_DEF,
   parameter int LINE_LEN_MAX = alef_pkg::LINE_LEN_MAX_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_text_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_line_selected,
   output logic                                  rsp_starts_entry,
   output logic [9:0]                            rsp_line_length,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [alef_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]                      csr_data
);
   import alef_pkg::*;

   localparam int P_CAP = (PATTERN_MAX < LINE_LEN_MAX - 1) ? PATTERN_MAX : LINE_LEN_MAX - 1;
   localparam int PW    = $clog2(P_CAP + 1);
   localparam int LW    = $clog2(LINE_LEN_MAX + 1);

   // configuration
   match_mode_type mode_ff;
   logic [5:0]     pattern_length_ff;
   pattern_type    pattern_ff;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // line state
   logic [PATTERN_MAX-1:0][7:0] recent_ff, recent_in, recent_shift;
   logic [LW-1:0] chars_ff, chars_in, chars_inc;
   logic          substr_ff, substr_in;
   logic          prefix_eq_ff, prefix_eq_in;
   logic          header_ff, header_in;
   logic          entry_ff, entry_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_sel_ff, rsp_start_ff;
   logic [9:0]    rsp_len_ff;

   logic          req_accept, advance, is_newline;
   logic [PW-1:0] eff_len;
   logic [7:0]    pat_at_chars;
   logic          tail_hit, hit;
   logic [LW+9:0] chars_wide;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;
   assign is_newline = in_byte_ff == NEWLINE_BYTE;
   assign advance    = in_valid_ff && (!is_newline || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;

   always_comb begin
      if (32'(pattern_length_ff) > P_CAP) begin
         eff_len = PW'(P_CAP);
      end else begin
         eff_len = PW'(pattern_length_ff);
      end
   end

   always_comb begin
      if (32'(chars_ff) < PATTERN_BYTES) begin
         pat_at_chars = pattern_ff[chars_ff[4:0]];
      end else begin
         pat_at_chars = 8'h00;
      end
   end

   always_comb begin
      recent_shift[0] = in_byte_ff;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         recent_shift[k] = recent_ff[k-1];
      end
   end

   // the window sees the shifted bytes on a text byte, the held ones on newline
   assign recent_in = (advance && !is_newline) ? recent_shift : recent_ff;

   alef_tail_match #(
      .PATTERN_MAX(PATTERN_MAX),
      .PW         (PW)
   ) u_tail (
      .window_bytes(recent_in),
      .pattern     (pattern_ff),
      .match_len   (eff_len),
      .tail_hit    (tail_hit)
   );

   assign chars_inc  = (32'(chars_ff) < LINE_LEN_MAX) ? chars_ff + LW'(1) : chars_ff;
   assign chars_wide = {10'b0, chars_ff};

   always_comb begin
      unique case (mode_ff)
         MODE_PREFIX: hit = prefix_eq_ff && (32'(chars_ff) >= 32'(eff_len));
         MODE_SUFFIX: hit = (32'(chars_ff) >= 32'(eff_len)) && tail_hit;
         MODE_EXACT:  hit = prefix_eq_ff && (32'(chars_ff) == 32'(eff_len));
         default:     hit = substr_ff || (eff_len == '0);
      endcase
   end

   always_comb begin
      chars_in     = chars_ff;
      substr_in    = substr_ff;
      prefix_eq_in = prefix_eq_ff;
      header_in    = header_ff;
      entry_in     = entry_ff;
      if (advance) begin
         if (is_newline) begin
            if (header_ff) begin
               entry_in = hit;
            end
            chars_in     = '0;
            substr_in    = 1'b0;
            prefix_eq_in = 1'b1;
            header_in    = 1'b0;
         end else begin
            if (chars_ff == '0) begin
               header_in = !is_blank(in_byte_ff);
            end
            if ((32'(chars_ff) < 32'(eff_len)) && (in_byte_ff != pat_at_chars)) begin
               prefix_eq_in = 1'b0;
            end
            chars_in = chars_inc;
            if ((eff_len != '0) && (32'(chars_inc) >= 32'(eff_len)) && tail_hit) begin
               substr_in = 1'b1;
            end
         end
      end
   end

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (advance && is_newline) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_SUBSTRING;
         pattern_length_ff <= 6'd1;
         pattern_ff        <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MATCH_MODE:     mode_ff              <= match_mode_type'(csr_data[1:0]);
            CSR_PATTERN_LENGTH: pattern_length_ff    <= csr_data[5:0];
            CSR_PATTERN_0_7:    pattern_ff[7:0]      <= csr_data;
            CSR_PATTERN_8_15:   pattern_ff[15:8]     <= csr_data;
            CSR_PATTERN_16_23:  pattern_ff[23:16]    <= csr_data;
            CSR_PATTERN_24_31:  pattern_ff[31:24]    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         recent_ff    <= '0;
         chars_ff     <= '0;
         substr_ff    <= 1'b0;
         prefix_eq_ff <= 1'b1;
         header_ff    <= 1'b0;
         entry_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         recent_ff    <= recent_in;
         chars_ff     <= chars_in;
         substr_ff    <= substr_in;
         prefix_eq_ff <= prefix_eq_in;
         header_ff    <= header_in;
         entry_ff     <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_text_byte;
      end
      if (advance && is_newline) begin
         rsp_sel_ff   <= entry_in;
         rsp_start_ff <= header_ff;
         rsp_len_ff   <= chars_wide[9:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_selected = rsp_sel_ff;
   assign rsp_starts_entry  = rsp_start_ff;
   assign rsp_line_length   = rsp_len_ff;

   a_newline_gives_beat: assert property (@(posedge clock) disable iff (reset)
      (advance && is_newline) |=> rsp_valid_ff)
      else $error("newline beat did not reach the output register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(advance && is_newline))
      else $error("stalled result overwritten");

   a_line_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && is_newline) |=> (chars_ff == '0) && prefix_eq_ff && !substr_ff && !header_ff)
      else $error("line state not cleared after newline");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      32'(chars_ff) <= LINE_LEN_MAX)
      else $error("line count beyond saturation");

endmodule
`default_nettype wire
